@@ sv/tlrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrs_pkg
// Shared constants, status codes and divider request/response types for the
// telemetry run statistics block.
// ----------------------------------------------------------------------------
package tlrs_pkg;

    localparam int unsigned FRAME_LIMIT = 65536;
    localparam int unsigned CNT_W      = $clog2(FRAME_LIMIT) + 1;
    localparam int unsigned TS_W       = 32;
    localparam int unsigned VOLT_W     = 16;
    localparam int unsigned TEMP_W     = 16;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned RATE_W     = 26;
    localparam int unsigned MS_W       = 10;
    localparam int unsigned DIV_W      = 32;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [VOLT_W-1:0] LOW_VOLTAGE_RESET = VOLT_W'(22000);
    localparam logic [MS_W-1:0]   MS_PER_S          = MS_W'(1000);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TS_BAD   = 2'd1,
        ST_SINGLE   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ sv/tlrs_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrs_in_if
// Frame channel: valid/ready handshake with one telemetry frame per beat.
// ----------------------------------------------------------------------------
interface tlrs_in_if;

    logic                               valid;
    logic                               ready;
    logic [tlrs_pkg::TS_W-1:0]          stamp_ms;
    logic [tlrs_pkg::VOLT_W-1:0]        voltage_mv;
    logic signed [tlrs_pkg::TEMP_W-1:0] temp_dc;
    logic                               last_frame;

    modport source (
        output valid,
        input  ready,
        output stamp_ms,
        output voltage_mv,
        output temp_dc,
        output last_frame
    );

    modport sink (
        input  valid,
        output ready,
        input  stamp_ms,
        input  voltage_mv,
        input  temp_dc,
        input  last_frame
    );

endinterface

@@ sv/tlrs_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrs_out_if
// Summary channel: valid/ready handshake with one run summary per beat.
// ----------------------------------------------------------------------------
interface tlrs_out_if;

    logic                               valid;
    logic                               ready;
    logic [tlrs_pkg::CNT_W-1:0]         frame_cnt;
    logic [tlrs_pkg::VOLT_W-1:0]        voltage_min_mv;
    logic [tlrs_pkg::VOLT_W-1:0]        voltage_max_mv;
    logic signed [tlrs_pkg::TEMP_W-1:0] temperature_avg_tenths;
    logic [tlrs_pkg::CNT_W-1:0]         low_cnt;
    logic [tlrs_pkg::RATE_W-1:0]        rate_hz;
    logic [1:0]                         status;

    modport source (
        output valid,
        input  ready,
        output frame_cnt,
        output voltage_min_mv,
        output voltage_max_mv,
        output temperature_avg_tenths,
        output low_cnt,
        output rate_hz,
        output status
    );

    modport sink (
        input  valid,
        output ready,
        input  frame_cnt,
        input  voltage_min_mv,
        input  voltage_max_mv,
        input  temperature_avg_tenths,
        input  low_cnt,
        input  rate_hz,
        input  status
    );

endinterface

@@ sv/tlrs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrs_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlrs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tlrs_pkg::div_req_t req,
    output tlrs_pkg::div_rsp_t rsp
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [tlrs_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [tlrs_pkg::DIV_W-1:0]           quo_reg;
    logic [tlrs_pkg::DIV_W-1:0]           rem_reg;
    logic [tlrs_pkg::DIV_W-1:0]           dvs_reg;

    logic [tlrs_pkg::DIV_W:0]             trial;
    logic [tlrs_pkg::DIV_W+1:0]           diff;
    logic                                 fits;
    logic [tlrs_pkg::DIV_W-1:0]           quo_next;
    logic [tlrs_pkg::DIV_W-1:0]           rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[tlrs_pkg::DIV_W-1]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        fits     = ~diff[tlrs_pkg::DIV_W+1];
        rem_next = fits ? diff[tlrs_pkg::DIV_W-1:0] : trial[tlrs_pkg::DIV_W-1:0];
        quo_next = {quo_reg[tlrs_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tlrs_pkg::DIV_CNT_W'(tlrs_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/telemetry_run_statistics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_run_statistics
// Per-run statistics over telemetry frames; one summary per closed run.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          beat
//  in_ch     in   valid/ready        one frame (timestamp, voltage, temp, last)
//  out_ch    out  valid/ready        one run summary
//  cfg       in   cfg_we             low-voltage threshold in mV
//
//  A frame that does not close the run leaves the block ready for the next frame.
//  A closing frame holds the input through two passes of the shared divider
//  (average temperature, then frame rate) plus sequencing; the second pass
//  is skipped when the rate is forced to zero.
//  The summary sits in an output register; the next frame is taken while it
//  waits, and a new summary waits only for the previous one to be taken.
//  Reset clears the run counters and status and loads the threshold with 22000 mV.
// ----------------------------------------------------------------------------
module telemetry_run_statistics (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tlrs_pkg::VOLT_W-1:0]   cfg_wdata,
    tlrs_in_if.sink                       in_ch,
    tlrs_out_if.source                    out_ch
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_AVG_GO    = 5'b00010,
        S_AVG_WAIT  = 5'b00100,
        S_RATE_GO   = 5'b01000,
        S_RATE_WAIT = 5'b10000
    } state_t;

    localparam logic [tlrs_pkg::CNT_W-1:0] CNT_MAX = tlrs_pkg::CNT_W'(tlrs_pkg::FRAME_LIMIT);
    localparam logic [tlrs_pkg::CNT_W-1:0] CNT_ONE = tlrs_pkg::CNT_W'(1);

    state_t                              state_reg, state_next;
    logic                                done_reg, done_next;
    logic [tlrs_pkg::VOLT_W-1:0]         thr_reg;

    logic [tlrs_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [tlrs_pkg::VOLT_W-1:0]         vmin_reg, vmin_next;
    logic [tlrs_pkg::VOLT_W-1:0]         vmax_reg, vmax_next;
    logic signed [tlrs_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [tlrs_pkg::CNT_W-1:0]          low_reg, low_next;
    logic [tlrs_pkg::TS_W-1:0]           first_ts_reg, first_ts_next;
    logic [tlrs_pkg::TS_W-1:0]           prev_ts_reg, prev_ts_next;
    tlrs_pkg::status_t                   status_reg, status_next;
    logic                                ts_err_reg, ts_err_next;
    logic signed [tlrs_pkg::TEMP_W-1:0]  avg_reg, avg_next;
    logic [tlrs_pkg::RATE_W-1:0]         rate_reg, rate_next;

    logic                                out_valid_reg;
    logic                                in_fire;
    logic                                out_free;
    logic                                publish;
    logic                                sum_neg;
    logic [tlrs_pkg::SUM_W-1:0]          sum_mag;
    logic [tlrs_pkg::TS_W-1:0]           elapsed;
    logic                                rate_needed;
    logic [tlrs_pkg::CNT_W+tlrs_pkg::MS_W-1:0] rate_num;
    logic [tlrs_pkg::TEMP_W-1:0]         avg_mag;
    tlrs_pkg::status_t                   status_out;

    tlrs_pkg::div_req_t                  div_req;
    tlrs_pkg::div_rsp_t                  div_rsp;

    tlrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ch.ready = (state_reg == S_IDLE) && !done_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign publish     = done_reg && out_free;

    assign sum_neg     = sum_reg[tlrs_pkg::SUM_W-1];
    assign sum_mag     = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
    assign elapsed     = prev_ts_reg - first_ts_reg;
    assign rate_needed = (count_reg != CNT_ONE) && !ts_err_reg && (elapsed != '0);
    assign rate_num    = {{tlrs_pkg::MS_W{1'b0}}, count_reg - CNT_ONE}
                         * {{tlrs_pkg::CNT_W{1'b0}}, tlrs_pkg::MS_PER_S};
    assign avg_mag     = div_rsp.quotient[tlrs_pkg::TEMP_W-1:0];
    assign status_out  = ((count_reg == CNT_ONE) && (status_reg == tlrs_pkg::ST_OK))
                         ? tlrs_pkg::ST_SINGLE : status_reg;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = sum_mag;
        div_req.divisor  = tlrs_pkg::DIV_W'(count_reg);
        case (state_reg)
            S_AVG_GO:
            begin
                div_req.start = 1'b1;
            end
            S_RATE_GO:
            begin
                div_req.start    = rate_needed;
                div_req.dividend = tlrs_pkg::DIV_W'(rate_num);
                div_req.divisor  = elapsed;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        done_next     = done_reg;
        count_next    = count_reg;
        vmin_next     = vmin_reg;
        vmax_next     = vmax_reg;
        sum_next      = sum_reg;
        low_next      = low_reg;
        first_ts_next = first_ts_reg;
        prev_ts_next  = prev_ts_reg;
        status_next   = status_reg;
        ts_err_next   = ts_err_reg;
        avg_next      = avg_reg;
        rate_next     = rate_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (publish)
                begin
                    done_next     = 1'b0;
                    count_next    = '0;
                    vmin_next     = '0;
                    vmax_next     = '0;
                    sum_next      = '0;
                    low_next      = '0;
                    first_ts_next = '0;
                    prev_ts_next  = '0;
                    status_next   = tlrs_pkg::ST_OK;
                    ts_err_next   = 1'b0;
                end
                else if (in_fire)
                begin
                    if (count_reg >= CNT_MAX)
                    begin
                        status_next = tlrs_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            vmin_next     = in_ch.voltage_mv;
                            vmax_next     = in_ch.voltage_mv;
                            first_ts_next = in_ch.stamp_ms;
                        end
                        else
                        begin
                            if (in_ch.stamp_ms <= prev_ts_reg)
                            begin
                                ts_err_next = 1'b1;
                                if (status_reg != tlrs_pkg::ST_OVERFLOW)
                                begin
                                    status_next = tlrs_pkg::ST_TS_BAD;
                                end
                            end
                            if (in_ch.voltage_mv < vmin_reg)
                            begin
                                vmin_next = in_ch.voltage_mv;
                            end
                            if (in_ch.voltage_mv > vmax_reg)
                            begin
                                vmax_next = in_ch.voltage_mv;
                            end
                        end
                        prev_ts_next = in_ch.stamp_ms;
                        sum_next     = sum_reg
                                       + tlrs_pkg::SUM_W'(in_ch.temp_dc);
                        if (in_ch.voltage_mv < thr_reg)
                        begin
                            low_next = low_reg + 1'b1;
                        end
                        count_next = count_reg + 1'b1;
                    end
                    if (in_ch.last_frame)
                    begin
                        state_next = S_AVG_GO;
                    end
                end
            end
            S_AVG_GO:
            begin
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = sum_neg ? (~avg_mag + 1'b1) : avg_mag;
                    state_next = S_RATE_GO;
                end
            end
            S_RATE_GO:
            begin
                if (rate_needed)
                begin
                    state_next = S_RATE_WAIT;
                end
                else
                begin
                    rate_next  = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RATE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rate_next  = div_rsp.quotient[tlrs_pkg::RATE_W-1:0];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            thr_reg       <= tlrs_pkg::LOW_VOLTAGE_RESET;
            count_reg     <= '0;
            vmin_reg      <= '0;
            vmax_reg      <= '0;
            sum_reg       <= '0;
            low_reg       <= '0;
            first_ts_reg  <= '0;
            prev_ts_reg   <= '0;
            status_reg    <= tlrs_pkg::ST_OK;
            ts_err_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            count_reg    <= count_next;
            vmin_reg     <= vmin_next;
            vmax_reg     <= vmax_next;
            sum_reg      <= sum_next;
            low_reg      <= low_next;
            first_ts_reg <= first_ts_next;
            prev_ts_reg  <= prev_ts_next;
            status_reg   <= status_next;
            ts_err_reg   <= ts_err_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg  <= avg_next;
        rate_reg <= rate_next;
        if (publish)
        begin
            out_ch.frame_cnt              <= count_reg;
            out_ch.voltage_min_mv         <= vmin_reg;
            out_ch.voltage_max_mv         <= vmax_reg;
            out_ch.temperature_avg_tenths <= avg_reg;
            out_ch.low_cnt                <= low_reg;
            out_ch.rate_hz                <= rate_reg;
            out_ch.status                 <= status_out;
        end
    end

    assign out_ch.valid = out_valid_reg;

endmodule

@@ bench/telemetry_run_statistics_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_run_statistics_tb
// Drives runs of telemetry frames into the run statistics block and checks
// every run summary against a cycle-free software copy of the statistics.
// Corner runs come first, then random runs under several voltage thresholds.
// Both channels idle at random, with stretches where they do not idle at all.
// ----------------------------------------------------------------------------
module telemetry_run_statistics_tb;

    typedef struct {
        logic [tlrs_pkg::TS_W-1:0]          stamp_ms;
        logic [tlrs_pkg::VOLT_W-1:0]        voltage_mv;
        logic signed [tlrs_pkg::TEMP_W-1:0] temp_dc;
        logic                               last_frame;
    } frame_t;

    typedef struct {
        logic [tlrs_pkg::CNT_W-1:0]         frame_cnt;
        logic [tlrs_pkg::VOLT_W-1:0]        voltage_min_mv;
        logic [tlrs_pkg::VOLT_W-1:0]        voltage_max_mv;
        logic signed [tlrs_pkg::TEMP_W-1:0] temperature_avg_tenths;
        logic [tlrs_pkg::CNT_W-1:0]         low_cnt;
        logic [tlrs_pkg::RATE_W-1:0]        rate_hz;
        tlrs_pkg::status_t                  status;
    } summary_t;

    class run_summary_board;
        logic [tlrs_pkg::VOLT_W-1:0] low_thr;
        int unsigned                 frames_seen;
        logic [tlrs_pkg::VOLT_W-1:0] volt_lo;
        logic [tlrs_pkg::VOLT_W-1:0] volt_hi;
        longint                      temp_acc;
        int unsigned                 low_seen;
        logic [tlrs_pkg::TS_W-1:0]   ts_first;
        logic [tlrs_pkg::TS_W-1:0]   ts_prev;
        tlrs_pkg::status_t           status_acc;
        bit                          ts_fault;
        summary_t                    pending_summaries[$];
        int                          mismatches;
        int                          runs_checked;
        int                          frames_noted;

        function new();
            low_thr      = tlrs_pkg::LOW_VOLTAGE_RESET;
            mismatches   = 0;
            runs_checked = 0;
            frames_noted = 0;
            clear_run();
        endfunction

        function void clear_run();
            frames_seen = 0;
            volt_lo     = '0;
            volt_hi     = '0;
            temp_acc    = 0;
            low_seen    = 0;
            ts_first    = '0;
            ts_prev     = '0;
            status_acc  = tlrs_pkg::ST_OK;
            ts_fault    = 1'b0;
        endfunction

        function void note_frame(frame_t f);
            summary_t                  s;
            longint                    avg;
            logic [tlrs_pkg::TS_W-1:0] elapsed;
            longint unsigned           rate;
            tlrs_pkg::status_t         st;
            frames_noted++;
            if (frames_seen >= tlrs_pkg::FRAME_LIMIT)
            begin
                status_acc = tlrs_pkg::ST_OVERFLOW;
            end
            else
            begin
                if (frames_seen == 0)
                begin
                    volt_lo  = f.voltage_mv;
                    volt_hi  = f.voltage_mv;
                    ts_first = f.stamp_ms;
                end
                else
                begin
                    if (f.stamp_ms <= ts_prev)
                    begin
                        ts_fault = 1'b1;
                        if (status_acc != tlrs_pkg::ST_OVERFLOW)
                            status_acc = tlrs_pkg::ST_TS_BAD;
                    end
                    if (f.voltage_mv < volt_lo)
                        volt_lo = f.voltage_mv;
                    if (f.voltage_mv > volt_hi)
                        volt_hi = f.voltage_mv;
                end
                ts_prev = f.stamp_ms;
                temp_acc += longint'(f.temp_dc);
                if (f.voltage_mv < low_thr)
                    low_seen++;
                frames_seen++;
            end
            if (!f.last_frame)
                return;
            st   = status_acc;
            rate = 0;
            avg  = temp_acc / longint'(frames_seen);
            if (frames_seen == 1)
            begin
                if (st == tlrs_pkg::ST_OK)
                    st = tlrs_pkg::ST_SINGLE;
            end
            else if (!ts_fault)
            begin
                elapsed = ts_prev - ts_first;
                if (elapsed != 0)
                    rate = (longint'(frames_seen) - 1) * 1000 / longint'(elapsed);
            end
            s.frame_cnt              = frames_seen[tlrs_pkg::CNT_W-1:0];
            s.voltage_min_mv         = volt_lo;
            s.voltage_max_mv         = volt_hi;
            s.temperature_avg_tenths = avg[tlrs_pkg::TEMP_W-1:0];
            s.low_cnt                = low_seen[tlrs_pkg::CNT_W-1:0];
            s.rate_hz                = rate[tlrs_pkg::RATE_W-1:0];
            s.status                 = st;
            pending_summaries.push_back(s);
            clear_run();
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_summary(summary_t got);
            summary_t want;
            if (pending_summaries.size() == 0)
            begin
                report($sformatf("summary with no run pending, frame_cnt=%0d",
                                 got.frame_cnt));
                return;
            end
            want = pending_summaries.pop_front();
            runs_checked++;
            if (got.frame_cnt !== want.frame_cnt)
                report($sformatf("run %0d frame_cnt %h want %h", runs_checked,
                                 got.frame_cnt, want.frame_cnt));
            if (got.voltage_min_mv !== want.voltage_min_mv)
                report($sformatf("run %0d voltage_min_mv %h want %h", runs_checked,
                                 got.voltage_min_mv, want.voltage_min_mv));
            if (got.voltage_max_mv !== want.voltage_max_mv)
                report($sformatf("run %0d voltage_max_mv %h want %h", runs_checked,
                                 got.voltage_max_mv, want.voltage_max_mv));
            if (got.temperature_avg_tenths !== want.temperature_avg_tenths)
                report($sformatf("run %0d temperature_avg_tenths %h want %h",
                                 runs_checked, got.temperature_avg_tenths,
                                 want.temperature_avg_tenths));
            if (got.low_cnt !== want.low_cnt)
                report($sformatf("run %0d low_cnt %h want %h", runs_checked,
                                 got.low_cnt, want.low_cnt));
            if (got.rate_hz !== want.rate_hz)
                report($sformatf("run %0d rate_hz %h want %h", runs_checked,
                                 got.rate_hz, want.rate_hz));
            if (got.status !== want.status)
                report($sformatf("run %0d status %h want %h", runs_checked,
                                 got.status, want.status));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [tlrs_pkg::VOLT_W-1:0] cfg_wdata;

    tlrs_in_if  in_ch();
    tlrs_out_if out_ch();

    run_summary_board sb = new();

    int src_left    = 0;
    bit src_quiet   = 1'b0;
    int sink_left   = 0;
    bit sink_quiet  = 1'b0;
    int thr_changes = 1;

    telemetry_run_statistics i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_wait(inout int left, inout bit quiet);
        if (left == 0)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            left  = $urandom_range(20, 60);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_frame(logic [tlrs_pkg::TS_W-1:0] ts,
                              logic [tlrs_pkg::VOLT_W-1:0] v,
                              logic signed [tlrs_pkg::TEMP_W-1:0] t, logic last);
        frame_t f;
        f.stamp_ms   = ts;
        f.voltage_mv = v;
        f.temp_dc    = t;
        f.last_frame = last;
        in_ch.stamp_ms   <= ts;
        in_ch.voltage_mv <= v;
        in_ch.temp_dc    <= t;
        in_ch.last_frame <= last;
        in_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        sb.note_frame(f);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic push_frame(logic [tlrs_pkg::TS_W-1:0] ts,
                              logic [tlrs_pkg::VOLT_W-1:0] v,
                              logic signed [tlrs_pkg::TEMP_W-1:0] t, logic last);
        send_frame(ts, v, t, last);
        idle_gap(pick_wait(src_left, src_quiet));
    endtask

    // hold until every summary is back, then let the divider drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending_summaries.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_threshold(logic [tlrs_pkg::VOLT_W-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.low_thr = v;
        thr_changes++;
    endtask

    task automatic random_runs(int budget);
        int                                 n;
        int                                 i;
        int                                 d;
        int                                 near;
        bit                                 tidy;
        logic [tlrs_pkg::TS_W-1:0]          ts;
        logic [tlrs_pkg::VOLT_W-1:0]        v;
        logic signed [tlrs_pkg::TEMP_W-1:0] t;
        while (budget > 0)
        begin
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
            tidy = ($urandom_range(0, 99) < 85);
            ts   = $urandom_range(0, 32'hF000_0000);
            for (i = 0; i < n; i++)
            begin
                if (i > 0)
                begin
                    if (!tidy)
                        ts = $urandom;
                    else if ($urandom_range(0, 49) != 0)
                    begin
                        case ($urandom_range(0, 2))
                            0:       ts = ts + $urandom_range(1, 5);
                            1:       ts = ts + $urandom_range(1, 2000);
                            default: ts = ts + $urandom_range(1, 1 << 24);
                        endcase
                    end
                end
                if ($urandom_range(0, 9) < 3)
                begin
                    d    = $urandom_range(0, 4);
                    near = int'(sb.low_thr) + d - 2;
                    if (near < 0)
                        near = 0;
                    if (near > 65535)
                        near = 65535;
                    v = near[tlrs_pkg::VOLT_W-1:0];
                end
                else
                    v = tlrs_pkg::VOLT_W'($urandom);
                if ($urandom_range(0, 9) < 6)
                    t = tlrs_pkg::TEMP_W'($urandom);
                else
                begin
                    d = $urandom_range(0, 600);
                    t = tlrs_pkg::TEMP_W'(d - 200);
                end
                push_frame(ts, v, t, i == n - 1);
            end
            budget -= n;
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int k;
            k = pick_wait(sink_left, sink_quiet);
            if (k > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (k) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : summary_monitor
        summary_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.frame_cnt              = out_ch.frame_cnt;
            got.voltage_min_mv         = out_ch.voltage_min_mv;
            got.voltage_max_mv         = out_ch.voltage_max_mv;
            got.temperature_avg_tenths = out_ch.temperature_avg_tenths;
            got.low_cnt                = out_ch.low_cnt;
            got.rate_hz                = out_ch.rate_hz;
            got.status                 = tlrs_pkg::status_t'(out_ch.status);
            sb.check_summary(got);
        end
    end

    initial
    begin
        int errors;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.stamp_ms   = '0;
        in_ch.voltage_mv = '0;
        in_ch.temp_dc    = '0;
        in_ch.last_frame = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        push_frame(32'h0000_0000, 16'h0000, -32768, 1'b1);
        push_frame(32'hFFFF_FFFF, 16'hFFFF, 32767, 1'b1);
        push_frame(100, 22000, 0, 1'b0);
        push_frame(100, 21999, 10, 1'b1);
        push_frame(500, 30000, 100, 1'b0);
        push_frame(499, 10000, 101, 1'b1);
        push_frame(10, 30000, -1, 1'b0);
        push_frame(11, 20000, -1, 1'b0);
        push_frame(12, 25000, 0, 1'b1);
        push_frame(32'h0000_0000, 1, 5, 1'b0);
        push_frame(32'hFFFF_FFFF, 65534, 4, 1'b1);
        push_frame(32'hFFFF_FFF0, 40000, -5, 1'b0);
        push_frame(32'h0000_0005, 40001, -6, 1'b1);
        push_frame(1000, 23000, 250, 1'b0);
        push_frame(1250, 21000, 260, 1'b0);
        push_frame(1500, 24000, 255, 1'b0);
        push_frame(2000, 22500, 240, 1'b1);
        push_frame(7, 100, 1, 1'b0);
        push_frame(7, 200, 2, 1'b0);
        push_frame(8, 300, 3, 1'b0);
        push_frame(9, 400, 4, 1'b1);
        push_frame(0, 65535, -32768, 1'b0);
        push_frame(1, 0, -32768, 1'b1);
        settle();

        random_runs(115);
        settle();
        write_threshold(16'h0000);
        random_runs(115);
        settle();
        write_threshold(16'hFFFF);
        random_runs(115);
        settle();
        write_threshold(tlrs_pkg::VOLT_W'($urandom));
        random_runs(115);
        settle();
        write_threshold(16'h0001);
        random_runs(115);
        settle();
        write_threshold(tlrs_pkg::VOLT_W'($urandom));
        random_runs(20);
        settle();

        errors = sb.mismatches + sb.pending_summaries.size();
        $display("Checked %0d run summaries from %0d frames under %0d threshold settings,",
                 sb.runs_checked, sb.frames_noted, thr_changes);
        $display("with corner runs, timestamp faults and one-frame runs.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
sv/tlrs_pkg.sv
sv/tlrs_in_if.sv
sv/tlrs_out_if.sv
sv/tlrs_div.sv
sv/telemetry_run_statistics.sv
bench/telemetry_run_statistics_tb.sv
